### rtl/core/frc_pkg.sv
// frc_pkg: shared types and constants for the fog ramp colour table entry block
// used by frc_div_stage and fog_ramp_clut_entry; no dependencies
`timescale 1ns / 1ps

package frc_pkg;

    localparam int LEVEL_W     = 8;
    localparam int PROD_W      = 2 * LEVEL_W;
    localparam int ENTRY_W     = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEPS   = LEVEL_W / DIV_STAGES;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd5;

    typedef enum logic [1:0] {
        ALPHA_ZERO,
        ALPHA_MAX,
        ALPHA_RAMP
    } alpha_sel_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] rem;
        logic [LEVEL_W-1:0] num_lo;
        logic [LEVEL_W-1:0] quot;
        alpha_sel_t         sel;
        logic [LEVEL_W-1:0] slot;
    } div_item_t;

endpackage

### rtl/core/frc_div_stage.sv
// frc_div_stage: one registered stage of the restoring divider, DIV_STEPS bits per stage
// depends on frc_pkg
`timescale 1ns / 1ps

module frc_div_stage
    import frc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [LEVEL_W-1:0] divisor,
    input  logic               item_valid,
    input  div_item_t          item,
    output logic               item_valid_out,
    output div_item_t          item_out
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    always_comb
    begin
        logic [LEVEL_W:0] trial;
        item_next = item;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial = {item_next.rem, item_next.num_lo[LEVEL_W-1]};
            item_next.num_lo = {item_next.num_lo[LEVEL_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial = trial - {1'b0, divisor};
                item_next.quot = {item_next.quot[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                item_next.quot = {item_next.quot[LEVEL_W-2:0], 1'b0};
            end
            item_next.rem = trial[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid_out = valid_reg;
    assign item_out       = item_reg;

endmodule

### rtl/core/fog_ramp_clut_entry.sv
// fog_ramp_clut_entry: top level, linear fog alpha colour table entry generator
// depends on frc_pkg and frc_div_stage
`timescale 1ns / 1ps

// Takes one fog level per cycle and returns its packed colour table word (alpha, blue,
// green, red) and its swizzled table slot. The pipeline holds a compare stage, a
// multiply stage, four divider stages of two quotient bits each, and the output register.
// A new item is taken every cycle unless the output side stalls, which holds the whole
// pipeline. Registers are written through the cfg port, which is always ready, and should
// only be written while no items are in flight.

module fog_ramp_clut_entry
    import frc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [LEVEL_W-1:0]   level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [LEVEL_W-1:0]   slot,
    output logic [ENTRY_W-1:0]   entry
);

    logic [LEVEL_W-1:0] near_reg;
    logic [LEVEL_W-1:0] far_reg;
    logic [LEVEL_W-1:0] red_reg;
    logic [LEVEL_W-1:0] green_reg;
    logic [LEVEL_W-1:0] blue_reg;
    logic [LEVEL_W-1:0] alpha_reg;

    logic               advance;
    logic [LEVEL_W-1:0] span;

    logic               s0_valid_reg;
    logic [LEVEL_W-1:0] s0_diff_reg;
    alpha_sel_t         s0_sel_reg;
    logic [LEVEL_W-1:0] s0_slot_reg;
    alpha_sel_t         s0_sel_next;
    logic [LEVEL_W-1:0] slot_next;

    logic               s1_valid_reg;
    div_item_t          s1_item_reg;
    logic [PROD_W-1:0]  product;

    logic               dv_valid [DIV_STAGES+1];
    div_item_t          dv_item  [DIV_STAGES+1];

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] slot_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [LEVEL_W-1:0] fog_a;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign span      = far_reg - near_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= '0;
            far_reg   <= '1;
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            alpha_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NEAR:  near_reg  <= cfg_data;
                REG_FAR:   far_reg   <= cfg_data;
                REG_RED:   red_reg   <= cfg_data;
                REG_GREEN: green_reg <= cfg_data;
                REG_BLUE:  blue_reg  <= cfg_data;
                REG_ALPHA: alpha_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // stage 0: range compare and slot swizzle
    always_comb
    begin
        priority if (level <= near_reg)
            s0_sel_next = ALPHA_ZERO;
        else if (level > far_reg)
            s0_sel_next = ALPHA_MAX;
        else
            s0_sel_next = ALPHA_RAMP;
        slot_next    = ~level;
        slot_next[3] = ~level[4];
        slot_next[4] = ~level[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_diff_reg <= level - near_reg;
            s0_sel_reg  <= s0_sel_next;
            s0_slot_reg <= slot_next;
        end
    end

    // stage 1: scale by fog alpha
    assign product = PROD_W'(alpha_reg) * PROD_W'(s0_diff_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg.rem    <= product[PROD_W-1:LEVEL_W];
            s1_item_reg.num_lo <= product[LEVEL_W-1:0];
            s1_item_reg.quot   <= '0;
            s1_item_reg.sel    <= s0_sel_reg;
            s1_item_reg.slot   <= s0_slot_reg;
        end
    end

    // divider pipeline
    assign dv_valid[0] = s1_valid_reg;
    assign dv_item[0]  = s1_item_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        frc_div_stage u_stage (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .divisor        (span),
            .item_valid     (dv_valid[g]),
            .item           (dv_item[g]),
            .item_valid_out (dv_valid[g+1]),
            .item_out       (dv_item[g+1])
        );
    end

    // output stage
    always_comb
    begin
        unique case (dv_item[DIV_STAGES].sel)
            ALPHA_ZERO: fog_a = '0;
            ALPHA_MAX:  fog_a = {1'b0, alpha_reg[LEVEL_W-1:1]};
            ALPHA_RAMP: fog_a = {1'b0, dv_item[DIV_STAGES].quot[LEVEL_W-1:1]};
            default:    fog_a = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            slot_reg  <= dv_item[DIV_STAGES].slot;
            entry_reg <= {fog_a, blue_reg, green_reg, red_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign entry     = entry_reg;

endmodule
